// ----- rtl/core/xmte_pkg.sv -----
`timescale 1ns / 1ps
// xmte_pkg: constants, codes and the crc byte step for the xmodem transfer engine
// no dependencies; used by xmodem_transfer_engine

package xmte_pkg;

   // block sizes and buffer indexing
   localparam int BIG_BLOCK   = 1024;
   localparam int SMALL_BLOCK = 128;
   localparam int IDX_BITS    = $clog2(BIG_BLOCK);
   localparam int LEN_BITS    = IDX_BITS + 1;

   localparam logic [LEN_BITS-1:0] LEN_BIG   = LEN_BITS'(BIG_BLOCK);
   localparam logic [LEN_BITS-1:0] LEN_SMALL = LEN_BITS'(SMALL_BLOCK);

   // line control characters
   localparam logic [7:0] C_SOH = 8'h01;
   localparam logic [7:0] C_STX = 8'h02;
   localparam logic [7:0] C_EOT = 8'h04;
   localparam logic [7:0] C_ACK = 8'h06;
   localparam logic [7:0] C_NAK = 8'h15;
   localparam logic [7:0] C_CAN = 8'h18;
   localparam logic [7:0] C_CRQ = 8'h43;
   localparam logic [7:0] C_SUB = 8'h1A;

   localparam logic [7:0]  NUM_CHECK = 8'hFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   // request commands
   localparam logic [3:0] CMD_SEND   = 4'd0;
   localparam logic [3:0] CMD_RECV   = 4'd1;
   localparam logic [3:0] CMD_CANCEL = 4'd2;
   localparam logic [3:0] CMD_LINE   = 4'd3;
   localparam logic [3:0] CMD_TICK   = 4'd4;
   localparam logic [3:0] CMD_PULL   = 4'd5;
   localparam logic [3:0] CMD_FILE   = 4'd6;
   localparam logic [3:0] CMD_END    = 4'd7;
   localparam logic [3:0] CMD_DRAIN  = 4'd8;

   // run status
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEND = 3'd1;
   localparam logic [2:0] ST_RECV = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;
   localparam logic [2:0] ST_FAIL = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_NOSTART = 3'd1;
   localparam logic [2:0] ERR_TIMEOUT = 3'd2;
   localparam logic [2:0] ERR_ERRORS  = 3'd3;
   localparam logic [2:0] ERR_REMOTE  = 3'd4;
   localparam logic [2:0] ERR_LOCAL   = 3'd5;
   localparam logic [2:0] ERR_SEQ     = 3'd6;
   localparam logic [2:0] ERR_SINK    = 3'd7;

   // configuration register indexes
   localparam logic [3:0] REG_START_WAIT = 4'd0;
   localparam logic [3:0] REG_BLOCK_TMO  = 4'd1;
   localparam logic [3:0] REG_CHAR_TMO   = 4'd2;
   localparam logic [3:0] REG_POLL       = 4'd3;
   localparam logic [3:0] REG_PURGE      = 4'd4;
   localparam logic [3:0] REG_MAX_ERR    = 4'd5;
   localparam logic [3:0] REG_CRC_POLLS  = 4'd6;
   localparam logic [3:0] REG_FALLBACK   = 4'd7;

   // crc-16/xmodem, one byte folded in msb first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/xmte_ram.sv -----
`timescale 1ns / 1ps
// xmte_ram: generic single write, single read ram with registered read data
// no dependencies

module xmte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/xmodem_transfer_engine.sv -----
`timescale 1ns / 1ps
// xmodem_transfer_engine: xmodem sender and receiver, 128 and 1k blocks, sum or crc-16
// depends on xmte_pkg and xmte_ram (1024 x 8 block buffer)

// One request is taken at a time. A request is accepted in one cycle, carried out in
// the next and its response is registered in the response state once the output is
// free. A pull or drain that reads block data uses the buffer ram's read port in the
// execute cycle and its registered data in the response cycle. When the sender frames
// a block (start reply, ack, buffer full, file end, fallback to 128 bytes) the block
// check is recomputed by reading the block once through the single ram read port,
// after any SUB padding is written one byte a cycle. The receiver builds its check and
// the trailing SUB count byte by byte as data arrives, so a line byte needs no pass
// over the buffer. Configuration writes are taken in any cycle; csr_ready is always
// high.

module xmodem_transfer_engine #(
   parameter int CANCEL_RUN = 8,
   parameter int TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [7:0]  req_byte_value,
   input  logic [31:0] req_now_ms,
   input  logic        req_option,
   input  logic        req_sink_failed,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_need_data,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_last,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_error,
   output logic [31:0] rsp_block_count,
   output logic [15:0] rsp_pad_count,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int LB = xmte_pkg::LEN_BITS;
   localparam int IB = xmte_pkg::IDX_BITS;
   localparam int TB = TIME_BITS;
   localparam int CtlBits = $clog2(CANCEL_RUN + 1);
   localparam logic [CtlBits-1:0] CTL_RUN = CtlBits'(CANCEL_RUN);
   localparam logic [CtlBits-1:0] CTL_ONE = CtlBits'(1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_SSTART, PH_SFILL, PH_SDATA, PH_SACK, PH_SEOT, PH_SEOTACK,
      PH_RWAIT, PH_RNUM, PH_RNUMINV, PH_RDATA, PH_RCHECK, PH_RPURGE
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE, SQ_EXEC, SQ_FRAME, SQ_PAD, SQ_SCAN, SQ_RESP
   } seq_type;

   // deadline reached when the wrapped difference is in the lower half
   function automatic logic time_up(input logic [TB-1:0] now, input logic [TB-1:0] t);
      logic [TB-1:0] d;
      d = now - t;
      return !d[TB-1];
   endfunction

   // configuration registers
   logic [31:0] cfg_start_wait_ff, cfg_block_tmo_ff, cfg_char_tmo_ff, cfg_poll_ff;
   logic [31:0] cfg_purge_ff;
   logic [7:0]  cfg_max_err_ff, cfg_crc_polls_ff, cfg_fallback_ff;

   // sequencer and latched request
   seq_type      seq_ff, seq_in;
   logic [3:0]   cmd_ff, cmd_in;
   logic [7:0]   byte_ff, byte_in;
   logic [TB-1:0] now_ff, now_in;
   logic         opt_ff, opt_in, sink_ff, sink_in;

   // protocol state
   phase_type    phase_ff, phase_in;
   logic [2:0]   run_status_ff, run_status_in, error_code_ff, error_code_in;
   logic         crc_mode_ff, crc_mode_in, allow_big_ff, allow_big_in;
   logic         started_ff, started_in, live_ff, live_in;
   logic         eot_seen_ff, eot_seen_in, eot_nak_ff, eot_nak_in;
   logic [7:0]   expected_ff, expected_in, rnum_ff, rnum_in;
   logic [1:0]   cancel_ff, cancel_in;
   logic [7:0]   retry_ff, retry_in, poll_ff, poll_in;
   logic [TB-1:0] deadline_ff, deadline_in, last_heard_ff, last_heard_in;
   logic [TB-1:0] purge_begin_ff, purge_begin_in;
   logic [31:0]  block_total_ff, block_total_in;
   logic [15:0]  pad_total_ff, pad_total_in;
   logic [7:0]   ctl_byte_ff, ctl_byte_in;
   logic [CtlBits-1:0] ctl_left_ff, ctl_left_in;
   logic [LB-1:0] out_pos_ff, out_pos_in, fill_ff, fill_in, offset_ff, offset_in;
   logic [LB-1:0] blen_ff, blen_in, bidx_ff, bidx_in;
   logic [7:0]   check0_ff, check0_in, check1_ff, check1_in;
   logic [15:0]  acc_ff, acc_in;
   logic [LB-1:0] sub_run_ff, sub_run_in;

   // sweep pointer and pending read
   logic [LB-1:0] ptr_ff, ptr_in;
   logic         pend_ff, pend_in;

   // pending result of the current request
   logic         res_txv_ff, res_txv_in, res_ram_ff, res_ram_in;
   logic [7:0]   res_txb_ff, res_txb_in;
   logic         res_dv_ff, res_dv_in, res_dl_ff, res_dl_in;

   // response registers
   logic         rsp_valid_ff, rsp_valid_in, rsp_txv_ff, rsp_txv_in;
   logic [7:0]   rsp_txb_ff, rsp_txb_in, rsp_db_ff, rsp_db_in;
   logic         rsp_need_ff, rsp_need_in, rsp_dv_ff, rsp_dv_in, rsp_dl_ff, rsp_dl_in;
   logic [2:0]   rsp_st_ff, rsp_st_in, rsp_err_ff, rsp_err_in;
   logic [31:0]  rsp_blk_ff, rsp_blk_in;
   logic [15:0]  rsp_pad_ff, rsp_pad_in;

   // block buffer ports
   logic          ram_we, ram_re;
   logic [IB-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // step temporaries and deferred actions
   logic          go_frame, go_build, do_retx, do_purge, do_heard_can, do_abort, do_fail;
   logic [2:0]    fail_code;
   logic          ok_v, got_v;
   logic [LB-1:0] total_v, pos_v, rem_v, flen_v, sel_v;
   logic [16:0]   pad_sum_v;
   logic [TB-1:0] t_block, t_char, t_poll, t_purge, t_start;

   assign t_block = cfg_block_tmo_ff[TB-1:0];
   assign t_char  = cfg_char_tmo_ff[TB-1:0];
   assign t_poll  = cfg_poll_ff[TB-1:0];
   assign t_purge = cfg_purge_ff[TB-1:0];
   assign t_start = cfg_start_wait_ff[TB-1:0];

   assign req_ready = (seq_ff == SQ_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_valid    = rsp_txv_ff;
   assign rsp_tx_byte     = rsp_txb_ff;
   assign rsp_need_data   = rsp_need_ff;
   assign rsp_data_valid  = rsp_dv_ff;
   assign rsp_data_byte   = rsp_db_ff;
   assign rsp_data_last   = rsp_dl_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_error       = rsp_err_ff;
   assign rsp_block_count = rsp_blk_ff;
   assign rsp_pad_count   = rsp_pad_ff;

   // block buffer
   xmte_ram #(
      .WIDTH (8),
      .DEPTH (xmte_pkg::BIG_BLOCK)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // request sequencing and protocol step
   always_comb begin
      seq_in = seq_ff;
      cmd_in = cmd_ff; byte_in = byte_ff; now_in = now_ff; opt_in = opt_ff; sink_in = sink_ff;
      phase_in = phase_ff; run_status_in = run_status_ff; error_code_in = error_code_ff;
      crc_mode_in = crc_mode_ff; allow_big_in = allow_big_ff;
      started_in = started_ff; live_in = live_ff; eot_seen_in = eot_seen_ff;
      eot_nak_in = eot_nak_ff; expected_in = expected_ff; rnum_in = rnum_ff;
      cancel_in = cancel_ff; retry_in = retry_ff; poll_in = poll_ff;
      deadline_in = deadline_ff; last_heard_in = last_heard_ff;
      purge_begin_in = purge_begin_ff; block_total_in = block_total_ff;
      pad_total_in = pad_total_ff; ctl_byte_in = ctl_byte_ff; ctl_left_in = ctl_left_ff;
      out_pos_in = out_pos_ff; fill_in = fill_ff; offset_in = offset_ff;
      blen_in = blen_ff; bidx_in = bidx_ff; check0_in = check0_ff; check1_in = check1_ff;
      acc_in = acc_ff; sub_run_in = sub_run_ff; ptr_in = ptr_ff; pend_in = 1'b0;
      res_txv_in = res_txv_ff; res_ram_in = res_ram_ff; res_txb_in = res_txb_ff;
      res_dv_in = res_dv_ff; res_dl_in = res_dl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_txv_in = rsp_txv_ff; rsp_txb_in = rsp_txb_ff; rsp_db_in = rsp_db_ff;
      rsp_need_in = rsp_need_ff; rsp_dv_in = rsp_dv_ff; rsp_dl_in = rsp_dl_ff;
      rsp_st_in = rsp_st_ff; rsp_err_in = rsp_err_ff; rsp_blk_in = rsp_blk_ff;
      rsp_pad_in = rsp_pad_ff;
      ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_re = 1'b0; ram_raddr = '0;
      go_frame = 1'b0; go_build = 1'b0; do_retx = 1'b0; do_purge = 1'b0;
      do_heard_can = 1'b0; do_abort = 1'b0; do_fail = 1'b0; fail_code = xmte_pkg::ERR_NONE;
      ok_v = 1'b0; got_v = 1'b0; total_v = '0; pos_v = '0; rem_v = '0; flen_v = '0;
      sel_v = '0; pad_sum_v = '0;

      case (seq_ff)
         // take a request
         SQ_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               byte_in = req_byte_value;
               now_in = req_now_ms[TB-1:0];
               opt_in = req_option;
               sink_in = req_sink_failed;
               res_txv_in = 1'b0; res_ram_in = 1'b0; res_txb_in = '0;
               res_dv_in = 1'b0; res_dl_in = 1'b0;
               seq_in = SQ_EXEC;
            end
         end

         // carry out one request on the protocol state
         SQ_EXEC: begin
            // storage failure aborts the receive before the command
            if (sink_ff && run_status_in == xmte_pkg::ST_RECV) begin
               ctl_byte_in = xmte_pkg::C_CAN;
               ctl_left_in = CTL_RUN;
               live_in = 1'b0;
               run_status_in = xmte_pkg::ST_FAIL;
               error_code_in = xmte_pkg::ERR_SINK;
               phase_in = PH_IDLE;
            end

            // both starts clear the run state
            if (cmd_ff == xmte_pkg::CMD_SEND || cmd_ff == xmte_pkg::CMD_RECV) begin
               phase_in = PH_IDLE; run_status_in = xmte_pkg::ST_IDLE;
               error_code_in = xmte_pkg::ERR_NONE;
               crc_mode_in = 1'b0; allow_big_in = 1'b0;
               started_in = 1'b0; live_in = 1'b0; eot_seen_in = 1'b0; eot_nak_in = 1'b0;
               expected_in = 8'd1; rnum_in = '0; cancel_in = '0; retry_in = '0; poll_in = '0;
               deadline_in = '0; last_heard_in = '0; purge_begin_in = '0;
               block_total_in = '0; pad_total_in = '0; ctl_byte_in = '0; ctl_left_in = '0;
               out_pos_in = '0; fill_in = '0; offset_in = '0; blen_in = '0; bidx_in = '0;
               check0_in = '0; check1_in = '0;
            end

            case (cmd_ff)
               xmte_pkg::CMD_SEND: begin
                  allow_big_in = opt_ff;
                  run_status_in = xmte_pkg::ST_SEND;
                  phase_in = PH_SSTART;
                  last_heard_in = now_ff;
                  deadline_in = now_ff + t_start;
               end
               xmte_pkg::CMD_RECV: begin
                  crc_mode_in = opt_ff;
                  run_status_in = xmte_pkg::ST_RECV;
                  phase_in = PH_RWAIT;
                  last_heard_in = now_ff;
                  deadline_in = now_ff;
               end
               xmte_pkg::CMD_CANCEL: begin
                  if (run_status_in == xmte_pkg::ST_SEND || run_status_in == xmte_pkg::ST_RECV) begin
                     do_abort = 1'b1;
                     fail_code = xmte_pkg::ERR_LOCAL;
                  end
               end

               // line byte
               xmte_pkg::CMD_LINE: begin
                  last_heard_in = now_ff;
                  case (phase_in)
                     PH_SSTART: begin
                        if (byte_ff == xmte_pkg::C_NAK || byte_ff == xmte_pkg::C_CRQ) begin
                           crc_mode_in = (byte_ff == xmte_pkg::C_CRQ);
                           cancel_in = '0;
                           if (offset_in >= fill_in) begin
                              fill_in = '0; offset_in = '0; phase_in = PH_SFILL;
                           end else begin
                              go_frame = 1'b1;
                           end
                        end else if (byte_ff == xmte_pkg::C_CAN) begin
                           do_heard_can = 1'b1;
                        end else begin
                           cancel_in = '0;
                        end
                     end
                     PH_SFILL, PH_SDATA, PH_SEOT: begin
                        if (byte_ff == xmte_pkg::C_CAN) do_heard_can = 1'b1;
                        else cancel_in = '0;
                     end
                     PH_SACK: begin
                        if (byte_ff == xmte_pkg::C_ACK) begin
                           cancel_in = '0;
                           block_total_in = block_total_in + 32'd1;
                           offset_in = offset_in + blen_in;
                           expected_in = expected_in + 8'd1;
                           retry_in = '0;
                           live_in = 1'b0;
                           if (offset_in >= fill_in) begin
                              fill_in = '0; offset_in = '0; phase_in = PH_SFILL;
                           end else begin
                              go_frame = 1'b1;
                           end
                        end else if (byte_ff == xmte_pkg::C_NAK) begin
                           cancel_in = '0;
                           do_retx = 1'b1;
                        end else if (byte_ff == xmte_pkg::C_CAN) begin
                           do_heard_can = 1'b1;
                        end else begin
                           cancel_in = '0;
                        end
                     end
                     PH_SEOTACK: begin
                        if (byte_ff == xmte_pkg::C_ACK) begin
                           run_status_in = xmte_pkg::ST_DONE;
                           phase_in = PH_IDLE;
                        end else if (byte_ff == xmte_pkg::C_NAK) begin
                           cancel_in = '0;
                           if (!eot_nak_in) begin
                              eot_nak_in = 1'b1;
                              phase_in = PH_SEOT;
                              ctl_byte_in = xmte_pkg::C_EOT;
                              ctl_left_in = CTL_ONE;
                           end else begin
                              do_retx = 1'b1;
                           end
                        end else if (byte_ff == xmte_pkg::C_CAN) begin
                           do_heard_can = 1'b1;
                        end else begin
                           cancel_in = '0;
                        end
                     end
                     PH_RWAIT: begin
                        if (byte_ff == xmte_pkg::C_SOH || byte_ff == xmte_pkg::C_STX) begin
                           blen_in = (byte_ff == xmte_pkg::C_STX) ? xmte_pkg::LEN_BIG
                                                                  : xmte_pkg::LEN_SMALL;
                           started_in = 1'b1;
                           cancel_in = '0;
                           bidx_in = '0;
                           eot_seen_in = 1'b0;
                           fill_in = '0;
                           offset_in = '0;
                           phase_in = PH_RNUM;
                           deadline_in = now_ff + t_char;
                        end else if (byte_ff == xmte_pkg::C_EOT) begin
                           if (!eot_seen_in) begin
                              eot_seen_in = 1'b1;
                              ctl_byte_in = xmte_pkg::C_NAK;
                              ctl_left_in = CTL_ONE;
                              deadline_in = now_ff + t_block;
                           end else begin
                              ctl_byte_in = xmte_pkg::C_ACK;
                              ctl_left_in = CTL_ONE;
                              run_status_in = xmte_pkg::ST_DONE;
                              phase_in = PH_IDLE;
                           end
                        end else if (byte_ff == xmte_pkg::C_CAN) begin
                           do_heard_can = 1'b1;
                        end else begin
                           cancel_in = '0;
                        end
                     end
                     PH_RNUM: begin
                        rnum_in = byte_ff;
                        phase_in = PH_RNUMINV;
                        deadline_in = now_ff + t_char;
                     end
                     PH_RNUMINV: begin
                        if (8'(rnum_in + byte_ff) != xmte_pkg::NUM_CHECK) begin
                           do_purge = 1'b1;
                        end else begin
                           bidx_in = '0;
                           phase_in = PH_RDATA;
                           deadline_in = now_ff + t_char;
                           acc_in = '0;
                           sub_run_in = '0;
                        end
                     end
                     PH_RDATA: begin
                        // store the byte and fold it into the check and the pad run
                        ram_we = 1'b1;
                        ram_waddr = bidx_in[IB-1:0];
                        ram_wdata = byte_ff;
                        acc_in = crc_mode_in ? xmte_pkg::crc_step(acc_in, byte_ff)
                                             : {8'h00, 8'(acc_in[7:0] + byte_ff)};
                        sub_run_in = (byte_ff == xmte_pkg::C_SUB) ? sub_run_in + 1'b1 : '0;
                        bidx_in = bidx_in + 1'b1;
                        deadline_in = now_ff + t_char;
                        if (bidx_in >= blen_in) begin
                           bidx_in = '0;
                           phase_in = PH_RCHECK;
                        end
                     end
                     PH_RCHECK: begin
                        if (bidx_in[0]) check1_in = byte_ff;
                        else check0_in = byte_ff;
                        bidx_in = bidx_in + 1'b1;
                        deadline_in = now_ff + t_char;
                        if (bidx_in >= (crc_mode_in ? LB'(2) : LB'(1))) begin
                           // block complete
                           ok_v = crc_mode_in ? (acc_in == {check0_in, check1_in})
                                              : (acc_in[7:0] == check0_in);
                           if (!ok_v) begin
                              do_purge = 1'b1;
                           end else if (rnum_in == expected_in) begin
                              block_total_in = block_total_in + 32'd1;
                              if (sub_run_in == blen_in) begin
                                 pad_sum_v = {1'b0, pad_total_in} + 17'(sub_run_in);
                                 pad_total_in = pad_sum_v[16] ? 16'hFFFF : pad_sum_v[15:0];
                              end else begin
                                 pad_total_in = 16'(sub_run_in);
                              end
                              expected_in = expected_in + 8'd1;
                              retry_in = '0;
                              fill_in = blen_in;
                              offset_in = '0;
                              ctl_byte_in = xmte_pkg::C_ACK;
                              ctl_left_in = CTL_ONE;
                              phase_in = PH_RWAIT;
                              deadline_in = now_ff + t_block;
                           end else if (rnum_in == 8'(expected_in - 8'd1)) begin
                              ctl_byte_in = xmte_pkg::C_ACK;
                              ctl_left_in = CTL_ONE;
                              phase_in = PH_RWAIT;
                              deadline_in = now_ff + t_block;
                           end else begin
                              do_abort = 1'b1;
                              fail_code = xmte_pkg::ERR_SEQ;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end

               // time tick
               xmte_pkg::CMD_TICK: begin
                  if (run_status_in == xmte_pkg::ST_SEND || run_status_in == xmte_pkg::ST_RECV) begin
                     case (phase_in)
                        PH_SSTART: begin
                           if (time_up(now_ff, deadline_in)) begin
                              do_fail = 1'b1;
                              fail_code = xmte_pkg::ERR_NOSTART;
                           end
                        end
                        PH_SACK, PH_SEOTACK: begin
                           if (time_up(now_ff, deadline_in)) do_retx = 1'b1;
                        end
                        PH_RWAIT: begin
                           if (time_up(now_ff, deadline_in)) begin
                              if (!started_in) begin
                                 if (poll_in >= cfg_max_err_ff) begin
                                    do_fail = 1'b1;
                                    fail_code = xmte_pkg::ERR_NOSTART;
                                 end else begin
                                    if (crc_mode_in && poll_in >= cfg_crc_polls_ff)
                                       crc_mode_in = 1'b0;
                                    ctl_byte_in = crc_mode_in ? xmte_pkg::C_CRQ : xmte_pkg::C_NAK;
                                    ctl_left_in = CTL_ONE;
                                    poll_in = poll_in + 8'd1;
                                    deadline_in = now_ff + t_poll;
                                 end
                              end else if (eot_seen_in) begin
                                 ctl_byte_in = xmte_pkg::C_ACK;
                                 ctl_left_in = CTL_ONE;
                                 run_status_in = xmte_pkg::ST_DONE;
                                 phase_in = PH_IDLE;
                              end else begin
                                 ok_v = retry_in < cfg_max_err_ff;
                                 if (retry_in != 8'hFF) retry_in = retry_in + 8'd1;
                                 if (!ok_v) begin
                                    do_abort = 1'b1;
                                    fail_code = xmte_pkg::ERR_TIMEOUT;
                                 end else begin
                                    ctl_byte_in = xmte_pkg::C_NAK;
                                    ctl_left_in = CTL_ONE;
                                    deadline_in = now_ff + t_block;
                                 end
                              end
                           end
                        end
                        PH_RNUM, PH_RNUMINV, PH_RDATA, PH_RCHECK: begin
                           if (time_up(now_ff, deadline_in)) begin
                              ok_v = retry_in < cfg_max_err_ff;
                              if (retry_in != 8'hFF) retry_in = retry_in + 8'd1;
                              if (!ok_v) begin
                                 do_abort = 1'b1;
                                 fail_code = xmte_pkg::ERR_TIMEOUT;
                              end else begin
                                 ctl_byte_in = xmte_pkg::C_NAK;
                                 ctl_left_in = CTL_ONE;
                                 phase_in = PH_RWAIT;
                                 deadline_in = now_ff + t_block;
                              end
                           end
                        end
                        PH_RPURGE: begin
                           if (time_up(now_ff, last_heard_in + t_purge) ||
                               time_up(now_ff, purge_begin_in + t_block)) begin
                              ctl_byte_in = xmte_pkg::C_NAK;
                              ctl_left_in = CTL_ONE;
                              phase_in = PH_RWAIT;
                              deadline_in = now_ff + t_block;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end

               // pull of one outgoing line byte
               xmte_pkg::CMD_PULL: begin
                  if (ctl_left_in != '0) begin
                     res_txb_in = ctl_byte_in;
                     ctl_left_in = ctl_left_in - 1'b1;
                     got_v = 1'b1;
                  end
                  if (live_in) begin
                     total_v = LB'(3) + blen_in + (crc_mode_in ? LB'(2) : LB'(1));
                     if (!got_v && out_pos_in < total_v) begin
                        pos_v = out_pos_in;
                        out_pos_in = out_pos_in + 1'b1;
                        if (pos_v == LB'(0)) begin
                           res_txb_in = (blen_in == xmte_pkg::LEN_BIG) ? xmte_pkg::C_STX
                                                                       : xmte_pkg::C_SOH;
                        end else if (pos_v == LB'(1)) begin
                           res_txb_in = expected_in;
                        end else if (pos_v == LB'(2)) begin
                           res_txb_in = ~expected_in;
                        end else if (pos_v < LB'(3) + blen_in) begin
                           sel_v = offset_in + pos_v - LB'(3);
                           ram_re = 1'b1;
                           ram_raddr = sel_v[IB-1:0];
                           res_ram_in = 1'b1;
                        end else begin
                           sel_v = pos_v - LB'(3) - blen_in;
                           res_txb_in = sel_v[0] ? check1_in : check0_in;
                        end
                        got_v = 1'b1;
                     end
                     if (out_pos_in >= total_v) begin
                        live_in = 1'b0;
                        if (phase_in == PH_SDATA) begin
                           phase_in = PH_SACK;
                           deadline_in = now_ff + t_block;
                        end
                     end
                  end
                  if (phase_in == PH_SEOT && ctl_left_in == '0 && !live_in) begin
                     phase_in = PH_SEOTACK;
                     deadline_in = now_ff + t_block;
                  end
                  res_txv_in = got_v;
               end

               // file byte into the send buffer
               xmte_pkg::CMD_FILE: begin
                  if (phase_in == PH_SFILL) begin
                     ram_we = 1'b1;
                     ram_waddr = fill_in[IB-1:0];
                     ram_wdata = byte_ff;
                     fill_in = fill_in + 1'b1;
                     if (fill_in >= xmte_pkg::LEN_BIG) go_frame = 1'b1;
                  end
               end
               xmte_pkg::CMD_END: begin
                  if (phase_in == PH_SFILL) begin
                     if (fill_in == '0) begin
                        phase_in = PH_SEOT;
                        retry_in = '0;
                        ctl_byte_in = xmte_pkg::C_EOT;
                        ctl_left_in = CTL_ONE;
                     end else begin
                        go_frame = 1'b1;
                     end
                  end
               end

               // drain one byte of an accepted block
               xmte_pkg::CMD_DRAIN: begin
                  if (run_status_in != xmte_pkg::ST_SEND && offset_in < fill_in) begin
                     ram_re = 1'b1;
                     ram_raddr = offset_in[IB-1:0];
                     res_dv_in = 1'b1;
                     offset_in = offset_in + 1'b1;
                     if (offset_in >= fill_in) begin
                        res_dl_in = 1'b1;
                        fill_in = '0;
                        offset_in = '0;
                     end
                  end
               end
               default: begin
               end
            endcase

            // two cancels in a row end the run
            if (do_heard_can) begin
               if (cancel_in != 2'd3) cancel_in = cancel_in + 2'd1;
               if (cancel_in >= 2'd2) begin
                  do_fail = 1'b1;
                  fail_code = xmte_pkg::ERR_REMOTE;
               end
            end

            // sender retry, with fallback from 1k to 128
            if (do_retx) begin
               ok_v = retry_in < cfg_max_err_ff;
               if (retry_in != 8'hFF) retry_in = retry_in + 8'd1;
               if (!ok_v) begin
                  do_abort = 1'b1;
                  fail_code = xmte_pkg::ERR_ERRORS;
               end else if (phase_in == PH_SEOT || phase_in == PH_SEOTACK) begin
                  phase_in = PH_SEOT;
                  ctl_byte_in = xmte_pkg::C_EOT;
                  ctl_left_in = CTL_ONE;
               end else begin
                  if (allow_big_in && blen_in == xmte_pkg::LEN_BIG &&
                      retry_in >= cfg_fallback_ff) begin
                     allow_big_in = 1'b0;
                     blen_in = xmte_pkg::LEN_SMALL;
                     go_build = 1'b1;
                  end
                  out_pos_in = '0;
                  live_in = 1'b1;
                  phase_in = PH_SDATA;
               end
            end

            // bad block: count it and wait for line silence, or abort past the error limit
            if (do_purge) begin
               ok_v = retry_in < cfg_max_err_ff;
               if (retry_in != 8'hFF) retry_in = retry_in + 8'd1;
               if (!ok_v) begin
                  do_abort = 1'b1;
                  fail_code = xmte_pkg::ERR_ERRORS;
               end else begin
                  phase_in = PH_RPURGE;
                  purge_begin_in = now_ff;
                  last_heard_in = now_ff;
               end
            end

            if (do_abort) begin
               ctl_byte_in = xmte_pkg::C_CAN;
               ctl_left_in = CTL_RUN;
               do_fail = 1'b1;
            end

            if (do_fail) begin
               live_in = 1'b0;
               if (run_status_in == xmte_pkg::ST_SEND) begin
                  fill_in = '0;
                  offset_in = '0;
               end
               run_status_in = xmte_pkg::ST_FAIL;
               error_code_in = fail_code;
               phase_in = PH_IDLE;
            end

            if (go_frame) begin
               seq_in = SQ_FRAME;
            end else if (go_build) begin
               ptr_in = '0;
               acc_in = '0;
               seq_in = SQ_SCAN;
            end else begin
               seq_in = SQ_RESP;
            end
         end

         // size the next block and decide on padding
         SQ_FRAME: begin
            rem_v = fill_ff - offset_ff;
            flen_v = (allow_big_ff && rem_v >= xmte_pkg::LEN_BIG) ? xmte_pkg::LEN_BIG
                                                                 : xmte_pkg::LEN_SMALL;
            blen_in = flen_v;
            out_pos_in = '0;
            live_in = 1'b1;
            phase_in = PH_SDATA;
            acc_in = '0;
            if (rem_v < flen_v) begin
               ptr_in = rem_v;
               fill_in = offset_ff + flen_v;
               seq_in = SQ_PAD;
            end else begin
               ptr_in = '0;
               seq_in = SQ_SCAN;
            end
         end

         // fill the short block with SUB
         SQ_PAD: begin
            sel_v = offset_ff + ptr_ff;
            ram_we = 1'b1;
            ram_waddr = sel_v[IB-1:0];
            ram_wdata = xmte_pkg::C_SUB;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_in == blen_ff) begin
               ptr_in = '0;
               seq_in = SQ_SCAN;
            end
         end

         // read the block once and build its check
         SQ_SCAN: begin
            if (ptr_ff < blen_ff) begin
               sel_v = offset_ff + ptr_ff;
               ram_re = 1'b1;
               ram_raddr = sel_v[IB-1:0];
               ptr_in = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               acc_in = crc_mode_ff ? xmte_pkg::crc_step(acc_ff, ram_rdata)
                                    : {8'h00, 8'(acc_ff[7:0] + ram_rdata)};
            end
            if (ptr_ff == blen_ff && !pend_ff) begin
               check0_in = crc_mode_ff ? acc_ff[15:8] : acc_ff[7:0];
               check1_in = crc_mode_ff ? acc_ff[7:0] : 8'h00;
               seq_in = SQ_RESP;
            end
         end

         // register the response once the output is free
         SQ_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_txv_in = res_txv_ff;
               rsp_txb_in = res_txv_ff ? (res_ram_ff ? ram_rdata : res_txb_ff) : 8'h00;
               rsp_dv_in = res_dv_ff;
               rsp_db_in = res_dv_ff ? ram_rdata : 8'h00;
               rsp_dl_in = res_dl_ff;
               rsp_need_in = (phase_ff == PH_SFILL);
               rsp_st_in = run_status_ff;
               rsp_err_in = error_code_ff;
               rsp_blk_in = block_total_ff;
               rsp_pad_in = pad_total_ff;
               seq_in = SQ_IDLE;
            end
         end

         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   // state, configuration and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_wait_ff <= 32'd60000;
         cfg_block_tmo_ff <= 32'd10000;
         cfg_char_tmo_ff <= 32'd1000;
         cfg_poll_ff <= 32'd3000;
         cfg_purge_ff <= 32'd1000;
         cfg_max_err_ff <= 8'd10;
         cfg_crc_polls_ff <= 8'd3;
         cfg_fallback_ff <= 8'd3;
         seq_ff <= SQ_IDLE;
         cmd_ff <= '0; byte_ff <= '0; now_ff <= '0; opt_ff <= 1'b0; sink_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         run_status_ff <= xmte_pkg::ST_IDLE;
         error_code_ff <= xmte_pkg::ERR_NONE;
         crc_mode_ff <= 1'b0; allow_big_ff <= 1'b0;
         started_ff <= 1'b0; live_ff <= 1'b0; eot_seen_ff <= 1'b0; eot_nak_ff <= 1'b0;
         expected_ff <= 8'd1; rnum_ff <= '0; cancel_ff <= '0; retry_ff <= '0; poll_ff <= '0;
         deadline_ff <= '0; last_heard_ff <= '0; purge_begin_ff <= '0;
         block_total_ff <= '0; pad_total_ff <= '0; ctl_byte_ff <= '0; ctl_left_ff <= '0;
         out_pos_ff <= '0; fill_ff <= '0; offset_ff <= '0; blen_ff <= '0; bidx_ff <= '0;
         check0_ff <= '0; check1_ff <= '0; acc_ff <= '0; sub_run_ff <= '0;
         ptr_ff <= '0; pend_ff <= 1'b0;
         res_txv_ff <= 1'b0; res_ram_ff <= 1'b0; res_txb_ff <= '0;
         res_dv_ff <= 1'b0; res_dl_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; rsp_txv_ff <= 1'b0; rsp_txb_ff <= '0; rsp_db_ff <= '0;
         rsp_need_ff <= 1'b0; rsp_dv_ff <= 1'b0; rsp_dl_ff <= 1'b0;
         rsp_st_ff <= xmte_pkg::ST_IDLE; rsp_err_ff <= xmte_pkg::ERR_NONE;
         rsp_blk_ff <= '0; rsp_pad_ff <= '0;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               xmte_pkg::REG_START_WAIT: cfg_start_wait_ff <= csr_data;
               xmte_pkg::REG_BLOCK_TMO:  cfg_block_tmo_ff <= csr_data;
               xmte_pkg::REG_CHAR_TMO:   cfg_char_tmo_ff <= csr_data;
               xmte_pkg::REG_POLL:       cfg_poll_ff <= csr_data;
               xmte_pkg::REG_PURGE:      cfg_purge_ff <= csr_data;
               xmte_pkg::REG_MAX_ERR:    cfg_max_err_ff <= csr_data[7:0];
               xmte_pkg::REG_CRC_POLLS:  cfg_crc_polls_ff <= csr_data[7:0];
               xmte_pkg::REG_FALLBACK:   cfg_fallback_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         seq_ff <= seq_in;
         cmd_ff <= cmd_in; byte_ff <= byte_in; now_ff <= now_in; opt_ff <= opt_in;
         sink_ff <= sink_in;
         phase_ff <= phase_in; run_status_ff <= run_status_in; error_code_ff <= error_code_in;
         crc_mode_ff <= crc_mode_in; allow_big_ff <= allow_big_in;
         started_ff <= started_in; live_ff <= live_in; eot_seen_ff <= eot_seen_in;
         eot_nak_ff <= eot_nak_in; expected_ff <= expected_in; rnum_ff <= rnum_in;
         cancel_ff <= cancel_in; retry_ff <= retry_in; poll_ff <= poll_in;
         deadline_ff <= deadline_in; last_heard_ff <= last_heard_in;
         purge_begin_ff <= purge_begin_in; block_total_ff <= block_total_in;
         pad_total_ff <= pad_total_in; ctl_byte_ff <= ctl_byte_in; ctl_left_ff <= ctl_left_in;
         out_pos_ff <= out_pos_in; fill_ff <= fill_in; offset_ff <= offset_in;
         blen_ff <= blen_in; bidx_ff <= bidx_in; check0_ff <= check0_in;
         check1_ff <= check1_in; acc_ff <= acc_in; sub_run_ff <= sub_run_in;
         ptr_ff <= ptr_in; pend_ff <= pend_in;
         res_txv_ff <= res_txv_in; res_ram_ff <= res_ram_in; res_txb_ff <= res_txb_in;
         res_dv_ff <= res_dv_in; res_dl_ff <= res_dl_in;
         rsp_valid_ff <= rsp_valid_in; rsp_txv_ff <= rsp_txv_in; rsp_txb_ff <= rsp_txb_in;
         rsp_db_ff <= rsp_db_in; rsp_need_ff <= rsp_need_in; rsp_dv_ff <= rsp_dv_in;
         rsp_dl_ff <= rsp_dl_in; rsp_st_ff <= rsp_st_in; rsp_err_ff <= rsp_err_in;
         rsp_blk_ff <= rsp_blk_in; rsp_pad_ff <= rsp_pad_in;
      end
   end

endmodule
